FILE: sv/prf_pkg.sv
// ============================================================================
// prf_pkg
// Shared types, constants and the fixed colour palette of the frame refresher.
// ============================================================================
package prf_pkg;

    // Frame geometry
    localparam int FRAME_ENTRIES = 64;
    localparam int F_AW          = $clog2(FRAME_ENTRIES);
    localparam int PIX_IDX_W     = 6;

    // Received byte codes
    localparam logic [7:0] RX_NONE      = 8'h00;
    localparam logic [7:0] RESTART_CODE = 8'h20;

    typedef logic [7:0]           t_byte;
    typedef logic [PIX_IDX_W-1:0] t_pix_idx;
    typedef logic [F_AW-1:0]      t_addr;

    // Map a 4-bit palette index to an RRRGGGBB colour
    function automatic t_byte palette_color(input logic [3:0] idx);
        t_byte c;
        case (idx)
            4'd0:    c = 8'hF0;
            4'd1:    c = 8'hE0;
            4'd2:    c = 8'h40;
            4'd3:    c = 8'hE8;
            4'd4:    c = 8'hFC;
            4'd5:    c = 8'h1C;
            4'd6:    c = 8'h0C;
            4'd7:    c = 8'h5E;
            4'd8:    c = 8'h1F;
            4'd9:    c = 8'h07;
            4'd10:   c = 8'h02;
            4'd11:   c = 8'h46;
            4'd12:   c = 8'hE3;
            4'd13:   c = 8'hFF;
            4'd14:   c = 8'h4A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/prf_in_if.sv
// ============================================================================
// prf_in_if
// Request channel carrying one received byte.
// ============================================================================
interface prf_in_if import prf_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: sv/prf_out_if.sv
// ============================================================================
// prf_out_if
// Request channel carrying one frame entry of a refresh.
// ============================================================================
interface prf_out_if import prf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_byte    pixel_color;
    t_pix_idx pixel_index;
    logic     frame_last;

    modport source (output valid, output pixel_color, output pixel_index,
                    output frame_last, input ready);
    modport sink   (input valid, input pixel_color, input pixel_index,
                    input frame_last, output ready);
endinterface

FILE: sv/palette_frame_refresher.sv
// ============================================================================
// palette_frame_refresher
// Writes palette colours from received bytes into a frame store and emits
// the whole frame after every received byte.
// ============================================================================
//
//  channel | dir | payload                               | one request is
//  --------+-----+---------------------------------------+------------------
//  i_in    | in  | rx_byte                               | one received byte
//  o_out   | out | pixel_color, pixel_index, frame_last  | one frame entry
//
//  Each byte is accepted, then its two colours (high nibble first) are written
//  into the frame store (skipped for the no-byte and restart codes), then all
//  FRAME_ENTRIES entries are read through the store's single read port.
//  Read data passes a registered read stage and an output register, so the
//  next byte is taken while the last entries of a frame still drain.
//  Reset (synchronous, active low) clears the position and all entry valid
//  bits at once; an unwritten entry reads as zero.
//  A stalled output holds the sweep; no entry is lost or repeated.
//
module palette_frame_refresher import prf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    prf_in_if.sink    i_in,
    prf_out_if.source o_out
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WR_HI = 2'd1;
    localparam logic [1:0] S_WR_LO = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    localparam t_addr LAST_ENTRY = F_AW'(FRAME_ENTRIES - 1);

    // Frame store and its valid bits
    t_byte                     mem [FRAME_ENTRIES];
    logic [FRAME_ENTRIES-1:0]  r_valid;

    logic [1:0] r_state, n_state;
    t_byte      r_byte;
    t_addr      r_pos,   n_pos;
    t_addr      r_k,     n_k;

    // Read stage
    logic       r_rd_vld;
    t_byte      r_rd_data;
    logic       r_rd_ok;
    t_addr      r_rd_idx;

    // Output register
    logic       r_o_vld;
    t_byte      r_o_color;
    t_addr      r_o_idx;
    logic       r_o_last;

    logic       in_acc;
    logic       out_take;
    logic       rd_issue;
    logic       wr_en;
    t_byte      wr_data;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_take = !r_o_vld || o_out.ready;
    assign rd_issue = (r_state == S_EMIT) && (!r_rd_vld || out_take);
    assign wr_en    = (r_state == S_WR_HI) || (r_state == S_WR_LO);
    assign wr_data  = (r_state == S_WR_HI) ? palette_color(r_byte[7:4])
                                           : palette_color(r_byte[3:0]);

    // Sequence one byte: decode, write, sweep
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_k     = r_k;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_k = '0;
                    if (i_in.rx_byte == RX_NONE) begin
                        n_state = S_EMIT;
                    end else if (i_in.rx_byte == RESTART_CODE) begin
                        n_pos   = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_WR_HI;
                    end
                end
            end
            S_WR_HI, S_WR_LO: begin
                n_pos   = (r_pos == LAST_ENTRY) ? '0 : r_pos + F_AW'(1);
                n_state = (r_state == S_WR_HI) ? S_WR_LO : S_EMIT;
            end
            S_EMIT: begin
                if (rd_issue) begin
                    n_k = r_k + F_AW'(1);
                    if (r_k == LAST_ENTRY) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_k     <= n_k;
        end
    end

    // Latch the accepted byte
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte <= i_in.rx_byte;
        end
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_pos] <= wr_data;
        end
        if (rd_issue) begin
            r_rd_data <= mem[r_k];
        end
    end

    // Mark written entries; reset clears them all
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[r_pos] <= 1'b1;
        end
    end

    // Read stage side information
    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_ok  <= r_valid[r_k];
            r_rd_idx <= r_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (rd_issue) begin
            r_rd_vld <= 1'b1;
        end else if (out_take) begin
            r_rd_vld <= 1'b0;
        end
    end

    // Output register: advance when empty or taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (out_take) begin
            r_o_vld <= r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take && r_rd_vld) begin
            r_o_color <= r_rd_ok ? r_rd_data : '0;
            r_o_idx   <= r_rd_idx;
            r_o_last  <= (r_rd_idx == LAST_ENTRY);
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_o_vld;
    assign o_out.pixel_color = r_o_color;
    assign o_out.pixel_index = PIX_IDX_W'(r_o_idx);
    assign o_out.frame_last  = r_o_last;

    // The low colour write always follows the high one
    a_wr_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR_LO) |-> ($past(r_state) == S_WR_HI))
        else $error("low write without high write");

    // Last mark only on the final entry
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_last) |-> (r_o_idx == LAST_ENTRY))
        else $error("frame_last on wrong entry");

    // Entries follow in order within a frame
    a_idx_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && o_out.ready && !r_o_last)
        |=> (!r_o_vld || (r_o_idx == $past(r_o_idx) + F_AW'(1))))
        else $error("frame entries out of order");

    // No byte is taken while a write or sweep is under way
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en || rd_issue) |-> !in_acc)
        else $error("byte accepted while busy");

endmodule
